@@ hdl/mbsrs_pkg.sv @@
// Shared types, constants and the mirror offset table for the bus read slave.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mbsrs_pkg;

  localparam int MIRROR_BYTES = 256;
  localparam int MIDX_W = (MIRROR_BYTES > 1) ? $clog2(MIRROR_BYTES) : 1;
  localparam int AD_W = 16;
  localparam int BYTE_W = 8;
  localparam int CNT_W = 32;
  localparam int OFS_VALUES = 256;

  typedef logic [MIDX_W-1:0] midx_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [AD_W-1:0] ad_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // One request as it leaves the front stage, mirror bytes already fetched.
  typedef struct packed {
    logic  kind;      // 1: mirror byte load
    logic  cs_act;    // chip select asserted
    logic  rd_act;    // read strobe asserted
    logic  wr_act;    // write strobe asserted
    logic  sel_edge;  // first selected sample since select went high
    logic  odd;       // latched address is odd
    ad_t   ad;
    byte_t lo;
    byte_t hi;
  } s1_item_t;

  // Byte offset (0..255) folded onto the mirror size.
  typedef midx_t mod_tbl_t [OFS_VALUES];

  function automatic mod_tbl_t build_mod_table();
    mod_tbl_t tbl;
    for (int i = 0; i < OFS_VALUES; i++) begin
      tbl[i] = midx_t'(i % MIRROR_BYTES);
    end
    return tbl;
  endfunction

  localparam mod_tbl_t MOD_TABLE = build_mod_table();

endpackage

`default_nettype wire

@@ hdl/mbsrs_front.sv @@
// Input register stage: select tracking, address latch and the byte mirror.
// Depends on mbsrs_pkg.
`default_nettype none

module mbsrs_front
  import mbsrs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     kind,
  input  wire logic     cs2_n,
  input  wire logic     rd_n,
  input  wire logic     wr_n,
  input  wire ad_t      ad_in,
  input  wire byte_t    mirror_index,
  input  wire byte_t    mirror_byte,
  output logic          s1_valid,
  input  wire logic     s1_ready,
  output s1_item_t      s1
);

  logic accept;
  logic select_seen;
  byte_t latched_address;
  logic new_edge;
  byte_t rd_ofs;
  byte_t rd_ofs_p1;
  midx_t lo_idx;
  midx_t hi_idx;
  midx_t wr_idx;

  byte_t mirror [MIRROR_BYTES];
  logic [MIRROR_BYTES-1:0] written;

  logic kind_q, cs_q, rd_q, wr_q, edge_q, odd_q;
  ad_t ad_q;
  byte_t lo_q, hi_q;
  logic lo_vld, hi_vld;

  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;

  // Address phase: the first selected sample latches the low byte of AD.
  assign new_edge  = !kind && !cs2_n && !select_seen;
  assign rd_ofs    = new_edge ? ad_in[BYTE_W-1:0] : latched_address;
  assign rd_ofs_p1 = rd_ofs + byte_t'(1);
  assign lo_idx    = MOD_TABLE[rd_ofs];
  assign hi_idx    = MOD_TABLE[rd_ofs_p1];
  assign wr_idx    = MOD_TABLE[mirror_index];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      select_seen     <= 1'b0;
      latched_address <= '0;
      written         <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
      if (accept && !kind) begin
        if (cs2_n) begin
          select_seen <= 1'b0;
        end else if (!select_seen) begin
          select_seen     <= 1'b1;
          latched_address <= ad_in[BYTE_W-1:0];
        end
      end
      if (accept && kind) begin
        written[wr_idx] <= 1'b1;
      end
    end
  end

  // Mirror store and its two registered read ports.
  always_ff @(posedge clk) begin
    if (accept && kind) begin
      mirror[wr_idx] <= mirror_byte;
    end
    if (accept) begin
      lo_q   <= mirror[lo_idx];
      hi_q   <= mirror[hi_idx];
      lo_vld <= written[lo_idx];
      hi_vld <= written[hi_idx];
      kind_q <= kind;
      cs_q   <= !cs2_n;
      rd_q   <= !rd_n;
      wr_q   <= !wr_n;
      edge_q <= new_edge;
      odd_q  <= rd_ofs[0];
      ad_q   <= ad_in;
    end
  end

  // Entries never loaded since reset read as zero.
  always_comb begin
    s1.kind     = kind_q;
    s1.cs_act   = cs_q;
    s1.rd_act   = rd_q;
    s1.wr_act   = wr_q;
    s1.sel_edge = edge_q;
    s1.odd      = odd_q;
    s1.ad       = ad_q;
    s1.lo       = lo_vld ? lo_q : '0;
    s1.hi       = hi_vld ? hi_q : '0;
  end

endmodule

`default_nettype wire

@@ hdl/mbsrs_core.sv @@
// Bus state update and result register: drivers, counters, address capture.
// Depends on mbsrs_pkg.
`default_nettype none

module mbsrs_core
  import mbsrs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s1_valid,
  output logic          s1_ready,
  input  wire s1_item_t s1,
  output logic          out_valid,
  input  wire logic     out_ready,
  output op_t           op,
  output ad_t           out_value,
  output logic          driving,
  output cnt_t          edge_count,
  output cnt_t          read_count,
  output cnt_t          write_count,
  output ad_t           edge_addr_reg,
  output ad_t           read_addr_reg,
  output ad_t           addr_or_reg,
  output byte_t         served_byte
);

  logic advance;
  op_t   op_next;
  ad_t   out_value_next;
  logic  driving_next;
  cnt_t  edge_count_next, read_count_next, write_count_next;
  ad_t   edge_addr_next, read_addr_next, addr_or_next;
  byte_t served_byte_next;

  assign s1_ready = !out_valid || out_ready;
  assign advance  = s1_valid && s1_ready;

  always_comb begin
    op_next          = OP_IDLE;
    out_value_next   = out_value;
    driving_next     = driving;
    edge_count_next  = edge_count;
    read_count_next  = read_count;
    write_count_next = write_count;
    edge_addr_next   = edge_addr_reg;
    read_addr_next   = read_addr_reg;
    addr_or_next     = addr_or_reg;
    served_byte_next = served_byte;
    if (!s1.kind) begin
      if (!s1.cs_act) begin
        driving_next = 1'b0;
      end else begin
        if (s1.sel_edge) begin
          edge_count_next = edge_count + cnt_t'(1);
          edge_addr_next  = s1.ad;
          addr_or_next    = addr_or_next | s1.ad;
        end
        if (s1.rd_act) begin
          // odd address: high byte reads as zero
          out_value_next = {(s1.odd ? byte_t'(0) : s1.hi), s1.lo};
          if (!driving) begin
            read_addr_next   = s1.ad;
            addr_or_next     = addr_or_next | s1.ad;
            read_count_next  = read_count + cnt_t'(1);
            served_byte_next = s1.lo;
          end
          driving_next = 1'b1;
          op_next      = OP_READ;
        end else if (s1.wr_act) begin
          driving_next     = 1'b0;
          write_count_next = write_count + cnt_t'(1);
          op_next          = OP_WRITE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      op            <= OP_IDLE;
      out_value     <= '0;
      driving       <= 1'b0;
      edge_count    <= '0;
      read_count    <= '0;
      write_count   <= '0;
      edge_addr_reg <= '0;
      read_addr_reg <= '0;
      addr_or_reg   <= '0;
      served_byte   <= '0;
    end else begin
      if (advance) begin
        out_valid     <= 1'b1;
        op            <= op_next;
        out_value     <= out_value_next;
        driving       <= driving_next;
        edge_count    <= edge_count_next;
        read_count    <= read_count_next;
        write_count   <= write_count_next;
        edge_addr_reg <= edge_addr_next;
        read_addr_reg <= read_addr_next;
        addr_or_reg   <= addr_or_next;
        served_byte   <= served_byte_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A write strobe without a read strobe releases the drivers.
  a_write_releases: assert property (@(posedge clk) disable iff (rst)
    (out_valid && op == OP_WRITE) |-> !driving)
    else $error("drivers enabled after a write strobe");

  // The read counter moves only on a served read with drivers on.
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(read_count)) |-> (op == OP_READ && driving))
    else $error("read count changed without a served read");

  // The write counter moves only on a seen write.
  a_write_count: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(write_count)) |-> (op == OP_WRITE && !driving))
    else $error("write count changed without a write");

  // State may change only when a request moves into the result register.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(edge_count) && $stable(out_value)))
    else $error("state changed while result stalled");

endmodule

`default_nettype wire

@@ hdl/multiplexed_bus_sram_read_slave_top.sv @@
// Top level of the multiplexed-bus read slave: front stage plus core stage.
// Depends on mbsrs_pkg, mbsrs_front and mbsrs_core.
`default_nettype none

// Usage:
//  - Input channel (in_valid/in_ready): one request per sampled bus cycle.
//    kind 0 carries a pin sample (cs2_n, rd_n, wr_n, ad_in); kind 1 loads
//    mirror_byte into the mirror at mirror_index.
//  - Output channel (out_valid/out_ready): exactly one result per request,
//    with the bus operation, the driver value/enable and all statistics
//    as they stand after that request.
//  - Path: an accepted request passes the front register with the mirror
//    read, then the result register, before its result appears.
//  - Throughput: one request per clock unless out_ready stalls; the single mirror
//    write port and its two registered read ports are used at most once per request.
//  - Reset (rst, synchronous): all counters, address registers and driver
//    state go to zero; the mirror's per-entry valid bits clear in the same
//    cycle, so unloaded bytes read as zero with no clearing pass.
//  - Receiver stall: the result register holds; the front stage keeps one
//    more request, after which in_ready drops until out_ready returns.
module multiplexed_bus_sram_read_slave_top
  import mbsrs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  kind,
  input  wire logic  cs2_n,
  input  wire logic  rd_n,
  input  wire logic  wr_n,
  input  wire ad_t   ad_in,
  input  wire byte_t mirror_index,
  input  wire byte_t mirror_byte,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [1:0] operation,
  output ad_t        ad_out,
  output logic       ad_enable,
  output cnt_t       select_edges,
  output cnt_t       read_total,
  output cnt_t       write_total,
  output ad_t        edge_address,
  output ad_t        read_address,
  output ad_t        addr_union,
  output byte_t      last_byte
);

  logic     s1_valid;
  logic     s1_ready;
  s1_item_t s1;
  op_t      op;

  // Front: select tracking and mirror lookup for the latched offset.
  mbsrs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .cs2_n        (cs2_n),
    .rd_n         (rd_n),
    .wr_n         (wr_n),
    .ad_in        (ad_in),
    .mirror_index (mirror_index),
    .mirror_byte  (mirror_byte),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .s1           (s1)
  );

  // Core: driver state, counters and the result register.
  mbsrs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1_ready      (s1_ready),
    .s1            (s1),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .op            (op),
    .out_value     (ad_out),
    .driving       (ad_enable),
    .edge_count    (select_edges),
    .read_count    (read_total),
    .write_count   (write_total),
    .edge_addr_reg (edge_address),
    .read_addr_reg (read_address),
    .addr_or_reg   (addr_union),
    .served_byte   (last_byte)
  );

  assign operation = op;

endmodule

`default_nettype wire

@@ bench/multiplexed_bus_sram_read_slave_top_tb.sv @@
// Self-checking bench for the multiplexed-bus read slave top level.
// Depends on mbsrs_pkg and multiplexed_bus_sram_read_slave_top; needs nothing else.
`default_nettype none

module multiplexed_bus_sram_read_slave_top_tb;
  import mbsrs_pkg::*;

  localparam logic KIND_PIN  = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // One request as offered on the input channel.
  typedef struct {
    logic  kind;
    logic  cs2_n;
    logic  rd_n;
    logic  wr_n;
    ad_t   ad;
    byte_t midx;
    byte_t mbyte;
  } bus_req_t;

  // One result as the block should report it.
  typedef struct {
    op_t   op;
    ad_t   ad_val;
    logic  ad_en;
    cnt_t  edges;
    cnt_t  reads;
    cnt_t  writes;
    ad_t   edge_addr;
    ad_t   read_addr;
    ad_t   addr_or;
    byte_t last;
  } bus_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // All block inputs start at known values.
  logic  in_valid     = 1'b0;
  logic  kind         = KIND_PIN;
  logic  cs2_n        = 1'b1;
  logic  rd_n         = 1'b1;
  logic  wr_n         = 1'b1;
  ad_t   ad_in        = '0;
  byte_t mirror_index = '0;
  byte_t mirror_byte  = '0;
  logic  out_ready    = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic [1:0] operation;
  ad_t        ad_out;
  logic       ad_enable;
  cnt_t       select_edges;
  cnt_t       read_total;
  cnt_t       write_total;
  ad_t        edge_address;
  ad_t        read_address;
  ad_t        addr_union;
  byte_t      last_byte;

  multiplexed_bus_sram_read_slave_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .cs2_n        (cs2_n),
    .rd_n         (rd_n),
    .wr_n         (wr_n),
    .ad_in        (ad_in),
    .mirror_index (mirror_index),
    .mirror_byte  (mirror_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .operation    (operation),
    .ad_out       (ad_out),
    .ad_enable    (ad_enable),
    .select_edges (select_edges),
    .read_total   (read_total),
    .write_total  (write_total),
    .edge_address (edge_address),
    .read_address (read_address),
    .addr_union   (addr_union),
    .last_byte    (last_byte)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bus_req_t    pending_reqs[$];
  bus_result_t expected_results[$];
  int          mismatch_count = 0;

  // Bench copy of the slave state.
  byte_t mirror_q [MIRROR_BYTES];
  ad_t   latched_q;
  logic  sel_seen_q;
  logic  driving_q;
  ad_t   out_val_q;
  cnt_t  edge_cnt_q;
  cnt_t  read_cnt_q;
  cnt_t  write_cnt_q;
  ad_t   edge_addr_q;
  ad_t   read_addr_q;
  ad_t   addr_or_q;
  byte_t served_q;

  task automatic clear_slave_model();
    foreach (mirror_q[i]) mirror_q[i] = '0;
    latched_q   = '0;
    sel_seen_q  = 1'b0;
    driving_q   = 1'b0;
    out_val_q   = '0;
    edge_cnt_q  = '0;
    read_cnt_q  = '0;
    write_cnt_q = '0;
    edge_addr_q = '0;
    read_addr_q = '0;
    addr_or_q   = '0;
    served_q    = '0;
  endtask

  // Offsets are folded to a byte first, then onto the mirror size.
  function automatic byte_t mirror_lookup(int unsigned ofs);
    return mirror_q[(ofs % 256) % MIRROR_BYTES];
  endfunction

  // Apply one accepted request and queue the result it must produce.
  task automatic advance_slave_model(input bus_req_t r);
    bus_result_t res;
    op_t         op;
    byte_t       ofs;
    ad_t         data;
    op = OP_IDLE;
    if (r.kind == KIND_LOAD) begin
      mirror_q[int'(r.midx) % MIRROR_BYTES] = r.mbyte;
    end else if (r.cs2_n) begin
      driving_q  = 1'b0;
      sel_seen_q = 1'b0;
    end else begin
      if (!sel_seen_q) begin
        latched_q   = r.ad;
        sel_seen_q  = 1'b1;
        edge_cnt_q  = edge_cnt_q + 1;
        edge_addr_q = r.ad;
        addr_or_q   = addr_or_q | r.ad;
      end
      if (!r.rd_n) begin
        ofs = latched_q[7:0];
        if (!driving_q) begin
          read_addr_q = r.ad;
          addr_or_q   = addr_or_q | r.ad;
        end
        data = {8'h00, mirror_lookup(ofs)};
        if (!latched_q[0]) data[15:8] = mirror_lookup(int'(ofs) + 1);
        out_val_q = data;
        if (!driving_q) begin
          driving_q  = 1'b1;
          read_cnt_q = read_cnt_q + 1;
          served_q   = data[7:0];
        end
        op = OP_READ;
      end else if (!r.wr_n) begin
        driving_q   = 1'b0;
        write_cnt_q = write_cnt_q + 1;
        op = OP_WRITE;
      end
    end
    res.op        = op;
    res.ad_val    = out_val_q;
    res.ad_en     = driving_q;
    res.edges     = edge_cnt_q;
    res.reads     = read_cnt_q;
    res.writes    = write_cnt_q;
    res.edge_addr = edge_addr_q;
    res.read_addr = read_addr_q;
    res.addr_or   = addr_or_q;
    res.last      = served_q;
    expected_results.push_back(res);
  endtask

  // Stimulus builders.
  task automatic add_pin(input logic cs_n, input logic rdn, input logic wrn, input ad_t ad);
    bus_req_t r;
    r.kind  = KIND_PIN;
    r.cs2_n = cs_n;
    r.rd_n  = rdn;
    r.wr_n  = wrn;
    r.ad    = ad;
    r.midx  = byte_t'($urandom);
    r.mbyte = byte_t'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic add_load(input byte_t idx, input byte_t val);
    bus_req_t r;
    r.kind  = KIND_LOAD;
    r.cs2_n = 1'($urandom);
    r.rd_n  = 1'($urandom);
    r.wr_n  = 1'($urandom);
    r.ad    = ad_t'($urandom);
    r.midx  = idx;
    r.mbyte = val;
    pending_reqs.push_back(r);
  endtask

  // One well-formed bus cycle with random content, sometimes bent.
  task automatic add_bus_cycle();
    ad_t addr;
    int  shape;
    int  n;
    addr  = ad_t'($urandom);
    shape = $urandom_range(0, 3);
    repeat ($urandom_range(0, 2)) add_pin(1'b1, 1'($urandom), 1'($urandom), ad_t'($urandom));
    // address phase; now and then the read strobe is already low at the select edge
    if ($urandom_range(0, 5) == 0) add_pin(1'b0, 1'b0, 1'b1, addr);
    else add_pin(1'b0, 1'b1, 1'b1, addr);
    repeat ($urandom_range(0, 2)) add_pin(1'b0, 1'b1, 1'b1, addr);
    if (shape <= 1 || shape == 3) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) add_load(byte_t'(addr + i), byte_t'($urandom));
        add_pin(1'b0, 1'b0, ($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1,
                (i == 0) ? addr : ad_t'($urandom));
      end
    end
    if (shape >= 2) begin
      n = $urandom_range(1, 3);
      repeat (n) add_pin(1'b0, 1'b1, 1'b0, ad_t'($urandom));
    end
    if ($urandom_range(0, 1) == 0) add_pin(1'b0, 1'b1, 1'b1, ad_t'($urandom));
    // a cycle sometimes ends without select going high again
    if ($urandom_range(0, 7) != 0) add_pin(1'b1, 1'b1, 1'b1, ad_t'($urandom));
  endtask

  // Driver: bursts of requests separated by random gaps.
  int gap_left   = 0;
  int burst_left = 8;

  always @(posedge clk) begin
    bus_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
      clear_slave_model();
    end else begin
      if (in_valid && in_ready) begin
        r.kind  = kind;
        r.cs2_n = cs2_n;
        r.rd_n  = rd_n;
        r.wr_n  = wr_n;
        r.ad    = ad_in;
        r.midx  = mirror_index;
        r.mbyte = mirror_byte;
        advance_slave_model(r);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          kind         <= r.kind;
          cs2_n        <= r.cs2_n;
          rd_n         <= r.rd_n;
          wr_n         <= r.wr_n;
          ad_in        <= r.ad;
          mirror_index <= r.midx;
          mirror_byte  <= r.mbyte;
          in_valid     <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall modes and one long hold-off that fills the block.
  int rx_cycle  = 0;
  int rx_mode   = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle = rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (rx_cycle == 500) hold_left = 400;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= 1'($urandom);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Monitor: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    bus_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("operation", 32'(e.op), 32'(operation));
        check_field("ad_out", 32'(e.ad_val), 32'(ad_out));
        check_field("ad_enable", 32'(e.ad_en), 32'(ad_enable));
        check_field("select_edges", e.edges, select_edges);
        check_field("read_total", e.reads, read_total);
        check_field("write_total", e.writes, write_total);
        check_field("edge_address", 32'(e.edge_addr), 32'(edge_address));
        check_field("read_address", 32'(e.read_addr), 32'(read_address));
        check_field("addr_union", 32'(e.addr_or), 32'(addr_union));
        check_field("last_byte", 32'(e.last), 32'(last_byte));
      end
    end
  end

  initial begin
    // Directed: mirror extremes, every bus operation and the corner cases.
    add_load(8'd254, 8'h01);
    add_load(8'd255, 8'hA5);
    add_load(8'd0, 8'hFF);
    add_load(8'd1, 8'h5A);
    add_pin(1'b1, 1'b1, 1'b1, 16'hFFFF);           // deselected idle
    add_pin(1'b0, 1'b1, 1'b1, 16'h00FE);           // select edge, no strobe
    add_pin(1'b0, 1'b0, 1'b1, 16'h1234);           // read, even address
    add_pin(1'b0, 1'b0, 1'b1, 16'hFFFF);           // repeated read sample
    add_load(8'd254, 8'h7E);                       // load during a read
    add_pin(1'b0, 1'b0, 1'b1, 16'h0000);           // refresh picks up new byte
    add_pin(1'b0, 1'b1, 1'b1, 16'h0000);           // strobe released, drivers held
    add_pin(1'b1, 1'b1, 1'b1, 16'h0000);
    add_pin(1'b0, 1'b0, 1'b1, 16'hFFFF);           // edge and read together, odd
    add_pin(1'b0, 1'b0, 1'b0, 16'h8001);           // read and write low: read wins
    add_pin(1'b0, 1'b1, 1'b0, 16'hAAAA);           // write releases drivers
    add_pin(1'b0, 1'b1, 1'b0, 16'h5555);
    add_pin(1'b1, 1'b0, 1'b0, 16'h0000);           // strobes without select
    add_pin(1'b0, 1'b1, 1'b0, 16'h0000);           // write at the select edge
    add_pin(1'b0, 1'b0, 1'b1, 16'h0101);
    add_pin(1'b1, 1'b1, 1'b1, 16'h0000);
    add_load(8'd128, 8'h80);
    add_pin(1'b0, 1'b1, 1'b1, 16'hFF80);
    add_pin(1'b0, 1'b0, 1'b1, 16'h0000);
    add_pin(1'b1, 1'b1, 1'b1, 16'hFFFF);
    // Random: mostly well-formed bus cycles, some loads and pin noise.
    while (pending_reqs.size() < 620) begin
      case ($urandom_range(0, 9))
        0, 1: add_load(byte_t'($urandom), byte_t'($urandom));
        2: add_pin(1'($urandom), 1'($urandom), 1'($urandom), ad_t'($urandom));
        default: add_bus_cycle();
      endcase
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0 && !out_valid) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
